// ----- rtl/core/pctd_pkg.sv -----
// ----------------------------------------------------------------------------
// pctd_pkg: shared definitions for the trial-division prime counter
// Widths, status and control-word types, step labels and the microcode table.
// ----------------------------------------------------------------------------
`default_nettype none

package pctd_pkg;

  // Width of the tested value and the derived datapath widths.
  localparam int ValueWidth = 32;
  localparam int CountWidth = 32;
  // The divisor never passes the square root of the largest positive value.
  localparam int DivWidth   = ValueWidth / 2 + 1;
  // Divisor squared, one bit wider than the value so the compare cannot wrap.
  localparam int SqWidth    = ValueWidth + 1;
  // Remainder unit walks the non-negative value one bit per cycle.
  localparam int RemBits    = ValueWidth - 1;
  localparam int IterWidth  = $clog2(RemBits);

  localparam logic [DivWidth-1:0]   FirstDivisor = DivWidth'(2);
  localparam logic [SqWidth-1:0]    FirstSquare  = SqWidth'(4);
  localparam logic [CountWidth-1:0] CountMax     = {CountWidth{1'b1}};

  // Microprogram counter.
  localparam int PcWidth = 3;
  typedef logic [PcWidth-1:0] pc_t;

  localparam pc_t StepFetch     = pc_t'(0);
  localparam pc_t StepSmall     = pc_t'(1);
  localparam pc_t StepBound     = pc_t'(2);
  localparam pc_t StepStart     = pc_t'(3);
  localparam pc_t StepWait      = pc_t'(4);
  localparam pc_t StepCheck     = pc_t'(5);
  localparam pc_t StepComposite = pc_t'(6);
  localparam pc_t StepEmit      = pc_t'(7);

  // Jump conditions selected by a control word.
  typedef enum logic [2:0] {
    CondNever   = 3'd0,
    CondNoIn    = 3'd1,
    CondSmall   = 3'd2,
    CondSqGt    = 3'd3,
    CondRemBusy = 3'd4,
    CondRemNz   = 3'd5,
    CondOutBusy = 3'd6,
    CondAlways  = 3'd7
  } cond_e;

  // One control word per step.
  typedef struct packed {
    logic  in_ready;   // offer the input channel
    logic  init_div;   // divisor back to two, square to four
    logic  set_prime;  // assume prime until a divisor is found
    logic  clr_prime;  // a divisor was found, or the value is too small
    logic  start_rem;  // launch the remainder unit
    logic  inc_div;    // next divisor, square updated incrementally
    logic  emit;       // load the result register when it is free
    cond_e cond;
    pc_t   target;
  } ctrl_t;

  // Datapath status seen by the sequencer.
  typedef struct packed {
    logic in_acc;
    logic too_small;
    logic sq_gt;
    logic rem_busy;
    logic rem_nz;
    logic out_busy;
  } status_t;

  // Microcode table.
  function automatic ctrl_t ucode_rom(input pc_t pc);
    ctrl_t w;
    w = '0;
    w.cond = CondNever;
    unique case (pc)
      StepFetch: begin
        w.in_ready = 1'b1;
        w.cond     = CondNoIn;
        w.target   = StepFetch;
      end
      StepSmall: begin
        w.init_div  = 1'b1;
        w.set_prime = 1'b1;
        w.cond      = CondSmall;
        w.target    = StepComposite;
      end
      StepBound: begin
        w.cond   = CondSqGt;
        w.target = StepEmit;
      end
      StepStart: begin
        w.start_rem = 1'b1;
      end
      StepWait: begin
        w.cond   = CondRemBusy;
        w.target = StepWait;
      end
      StepCheck: begin
        w.inc_div = 1'b1;
        w.cond    = CondRemNz;
        w.target  = StepBound;
      end
      StepComposite: begin
        w.clr_prime = 1'b1;
      end
      StepEmit: begin
        w.emit   = 1'b1;
        w.cond   = CondOutBusy;
        w.target = StepEmit;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/pctd_rem_unit.sv -----
// ----------------------------------------------------------------------------
// pctd_rem_unit: iterative remainder unit
// Restoring division, one dividend bit per cycle; only the remainder is kept.
// ----------------------------------------------------------------------------
`default_nettype none

module pctd_rem_unit (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  input  wire logic [pctd_pkg::RemBits-1:0]        dividend_i,
  input  wire logic [pctd_pkg::DivWidth-1:0]       divisor_i,
  output logic                                     busy_o,
  output logic                                     rem_nz_o
);

  logic                               busy_q, busy_d;
  logic [pctd_pkg::IterWidth-1:0]     iter_q, iter_d;
  logic [pctd_pkg::RemBits-1:0]       dvd_q, dvd_d;
  logic [pctd_pkg::DivWidth-1:0]      rem_q, rem_d;
  logic [pctd_pkg::DivWidth:0]        trial;
  logic [pctd_pkg::DivWidth:0]        diff;

  // One shift-and-subtract step.
  assign trial = {rem_q, dvd_q[pctd_pkg::RemBits-1]};
  assign diff  = trial - {1'b0, divisor_i};

  always_comb begin
    busy_d = busy_q;
    iter_d = iter_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      iter_d = pctd_pkg::IterWidth'(pctd_pkg::RemBits - 1);
      dvd_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      dvd_d = {dvd_q[pctd_pkg::RemBits-2:0], 1'b0};
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = diff[pctd_pkg::DivWidth-1:0];
      end else begin
        rem_d = trial[pctd_pkg::DivWidth-1:0];
      end
      if (iter_q == '0) begin
        busy_d = 1'b0;
      end else begin
        iter_d = iter_q - 1'b1;
      end
    end
  end

  // Control state is reset; the working registers are not.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    iter_q <= iter_d;
    dvd_q  <= dvd_d;
    rem_q  <= rem_d;
  end

  assign busy_o   = busy_q;
  assign rem_nz_o = |rem_q;

endmodule

`default_nettype wire

// ----- rtl/core/pctd_sequencer.sv -----
// ----------------------------------------------------------------------------
// pctd_sequencer: microprogram sequencer
// Step counter, microcode lookup and conditional jump selection.
// ----------------------------------------------------------------------------
`default_nettype none

module pctd_sequencer (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire pctd_pkg::status_t  status_i,
  output pctd_pkg::ctrl_t         ctrl_o,
  output pctd_pkg::pc_t           pc_o
);

  pctd_pkg::pc_t   pc_q, pc_d;
  pctd_pkg::ctrl_t ctrl;
  logic            take;

  assign ctrl = pctd_pkg::ucode_rom(pc_q);

  // Evaluate the jump condition of the current word.
  always_comb begin
    unique case (ctrl.cond)
      pctd_pkg::CondNever:   take = 1'b0;
      pctd_pkg::CondNoIn:    take = !status_i.in_acc;
      pctd_pkg::CondSmall:   take = status_i.too_small;
      pctd_pkg::CondSqGt:    take = status_i.sq_gt;
      pctd_pkg::CondRemBusy: take = status_i.rem_busy;
      pctd_pkg::CondRemNz:   take = status_i.rem_nz;
      pctd_pkg::CondOutBusy: take = status_i.out_busy;
      pctd_pkg::CondAlways:  take = 1'b1;
      default:               take = 1'b0;
    endcase
  end

  // Fall through wraps from the last step back to fetch.
  assign pc_d = take ? ctrl.target : pc_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= pctd_pkg::StepFetch;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctrl_o = ctrl;
  assign pc_o   = pc_q;

endmodule

`default_nettype wire

// ----- rtl/core/prime_counter_trial_division_core.sv -----
// ----------------------------------------------------------------------------
// prime_counter_trial_division_core: prime test and running prime count
// Trial division under microcode control, with a saturating per-list count.
// ----------------------------------------------------------------------------
//
//   channel | handshake              | payload
//   --------+------------------------+------------------------------------
//   input   | in_valid_i / in_ready_o | value_i[31:0], last_item_i
//   output  | out_valid_o / out_ready_i | is_prime_o, prime_count_o[31:0],
//           |                        | last_result_o
//
// One beat in gives one beat out. A value below two, negatives included, is
// marked not prime at once; any other value runs the bit-serial remainder
// unit once per trial divisor, from two upward, until a divisor leaves no
// remainder or the divisor's square passes the value.
// Reset clears the sequencer, the result register valid and the running count.
// A stalled output holds its beat; the next input beat is taken and worked on,
// and only its own result waits for the output register to free.
// ----------------------------------------------------------------------------
`default_nettype none

module prime_counter_trial_division_core (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic [pctd_pkg::ValueWidth-1:0]    value_i,
  input  wire logic                               last_item_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic                                    is_prime_o,
  output logic [pctd_pkg::CountWidth-1:0]         prime_count_o,
  output logic                                    last_result_o
);

  pctd_pkg::ctrl_t   ctrl;
  pctd_pkg::status_t status;
  pctd_pkg::pc_t     pc;

  logic [pctd_pkg::ValueWidth-1:0] value_q;
  logic                            last_q;
  logic                            prime_q, prime_d;
  logic [pctd_pkg::DivWidth-1:0]   div_q, div_d;
  logic [pctd_pkg::SqWidth-1:0]    sq_q, sq_d;
  logic [pctd_pkg::CountWidth-1:0] cnt_q, cnt_d, cnt_next;
  logic                            out_valid_q, out_valid_d;
  logic                            out_prime_q;
  logic [pctd_pkg::CountWidth-1:0] out_count_q;
  logic                            out_last_q;
  logic                            in_acc;
  logic                            out_free;
  logic                            out_load;
  logic                            rem_busy;
  logic                            rem_nz;

  // Sequencer.
  pctd_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl),
    .pc_o     (pc)
  );

  // Remainder unit for the current divisor.
  pctd_rem_unit u_rem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ctrl.start_rem),
    .dividend_i (value_q[pctd_pkg::RemBits-1:0]),
    .divisor_i  (div_q),
    .busy_o     (rem_busy),
    .rem_nz_o   (rem_nz)
  );

  // Handshakes.
  assign in_ready_o = ctrl.in_ready;
  assign in_acc     = in_valid_i && ctrl.in_ready;
  assign out_free   = !out_valid_q || out_ready_i;
  assign out_load   = ctrl.emit && out_free;

  // Status back to the sequencer.
  always_comb begin
    status.in_acc    = in_acc;
    status.too_small = value_q[pctd_pkg::ValueWidth-1] ||
                       (value_q < pctd_pkg::ValueWidth'(2));
    status.sq_gt     = sq_q > {{(pctd_pkg::SqWidth - pctd_pkg::ValueWidth){1'b0}}, value_q};
    status.rem_busy  = rem_busy;
    status.rem_nz    = rem_nz;
    status.out_busy  = !out_free;
  end

  // Divisor and its square; the square steps by 2d + 1.
  always_comb begin
    div_d = div_q;
    sq_d  = sq_q;
    if (ctrl.init_div) begin
      div_d = pctd_pkg::FirstDivisor;
      sq_d  = pctd_pkg::FirstSquare;
    end else if (ctrl.inc_div) begin
      div_d = div_q + 1'b1;
      sq_d  = sq_q + {{(pctd_pkg::SqWidth - pctd_pkg::DivWidth - 1){1'b0}}, div_q, 1'b1};
    end
  end

  // Prime flag for the item in progress.
  always_comb begin
    prime_d = prime_q;
    if (ctrl.set_prime) begin
      prime_d = 1'b1;
    end else if (ctrl.clr_prime) begin
      prime_d = 1'b0;
    end
  end

  // Saturating count; it returns to zero after a list's last item.
  always_comb begin
    cnt_next = cnt_q;
    if (prime_q && (cnt_q != pctd_pkg::CountMax)) begin
      cnt_next = cnt_q + 1'b1;
    end
    cnt_d = cnt_q;
    if (out_load) begin
      cnt_d = last_q ? '0 : cnt_next;
    end
  end

  // Result register valid.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk_i) begin
    div_q   <= div_d;
    sq_q    <= sq_d;
    prime_q <= prime_d;
    if (in_acc) begin
      value_q <= value_i;
      last_q  <= last_item_i;
    end
    if (out_load) begin
      out_prime_q <= prime_q;
      out_count_q <= cnt_next;
      out_last_q  <= last_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign is_prime_o    = out_prime_q;
  assign prime_count_o = out_count_q;
  assign last_result_o = out_last_q;

  // A prime result always carries a non-zero count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_prime_o) |-> (prime_count_o != '0))
    else $error("prime result with zero count");

  // The remainder unit is idle whenever a new beat is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> !rem_busy)
    else $error("input taken while remainder unit busy");

  // An accepted beat moves the sequencer to the small-value check.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (pc == pctd_pkg::StepSmall))
    else $error("sequencer did not leave fetch");

  // The count is clear after the result of a list's last item is loaded.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && last_q) |=> (cnt_q == '0))
    else $error("count not cleared at end of list");

endmodule

`default_nettype wire

// ----- test/prime_counter_trial_division_core_tb.sv -----
// ----------------------------------------------------------------------------
// prime_counter_trial_division_core_tb: self-checking bench for the prime counter
// Sends signed values in lists, predicts the prime flag and the running count
// for every beat, and compares each output beat with the oldest prediction.
// Both channels idle at random, and the output side holds off for long
// stretches to fill the block.
// ----------------------------------------------------------------------------

module prime_counter_trial_division_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit  = 8_000_000;
  localparam int unsigned LongHold    = 400;
  localparam int unsigned RandomBeats = 100;
  localparam int unsigned CalmBeats   = 20;
  localparam int unsigned SettleWait  = 64;

  // One predicted output beat.
  typedef struct packed {
    logic                            prime;
    logic [pctd_pkg::CountWidth-1:0] count;
    logic                            last;
  } verdict_t;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_ready;
  logic [pctd_pkg::ValueWidth-1:0] value;
  logic                            last_item;
  logic                            out_valid;
  logic                            out_ready;
  logic                            is_prime;
  logic [pctd_pkg::CountWidth-1:0] prime_count;
  logic                            last_result;

  verdict_t                        verdict_q[$];
  logic [pctd_pkg::CountWidth-1:0] prime_tally;
  bit                              idle_en;
  bit                              hold_request;
  int unsigned                     cycle_count;
  int unsigned                     error_count;
  int unsigned                     beats_sent;
  int unsigned                     beats_checked;
  int unsigned                     primes_seen;
  int unsigned                     lists_closed;

  prime_counter_trial_division_core dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .value_i       (value),
    .last_item_i   (last_item),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .is_prime_o    (is_prime),
    .prime_count_o (prime_count),
    .last_result_o (last_result)
  );

  always #10 clk = ~clk;

  // Trial division on the two's complement value; anything below two fails.
  function automatic bit survives_trial_division(logic [pctd_pkg::ValueWidth-1:0] raw);
    longint unsigned n;
    longint unsigned d;
    if (raw[pctd_pkg::ValueWidth-1]) return 1'b0;
    n = longint'(raw);
    if (n < 2) return 1'b0;
    for (d = 2; d * d <= n; d++) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Works out the output beat for an accepted value and updates the tally.
  task automatic predict_verdict(logic [pctd_pkg::ValueWidth-1:0] raw, logic closes_list);
    verdict_t v;
    v.prime = survives_trial_division(raw);
    if (v.prime && prime_tally != pctd_pkg::CountMax) prime_tally++;
    if (v.prime) primes_seen++;
    v.count = prime_tally;
    v.last  = closes_list;
    verdict_q.push_back(v);
    if (closes_list) begin
      prime_tally = '0;
      lists_closed++;
    end
  endtask

  // Offers one beat, entered and left at a falling edge. Valid stays high
  // between beats unless an idle gap is taken.
  task automatic send_value(logic [pctd_pkg::ValueWidth-1:0] raw, logic closes_list);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_valid  <= 1'b1;
    value     <= raw;
    last_item <= closes_list;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_verdict(raw, closes_list);
    beats_sent++;
    @(negedge clk);
  endtask

  // Stops offering beats until every predicted result has come out.
  task automatic pause_until_drained();
    in_valid <= 1'b0;
    wait (verdict_q.size() == 0);
    @(negedge clk);
  endtask

  // Mostly small values; large positive ones always have a small factor and
  // negative ones are rejected at once, so that the trial division stays short.
  function automatic logic [pctd_pkg::ValueWidth-1:0] pick_value();
    int unsigned sel;
    logic [pctd_pkg::ValueWidth-1:0] r;
    sel = $urandom_range(0, 99);
    r   = $urandom;
    if (sel < 50) return pctd_pkg::ValueWidth'($urandom_range(0, 4095));
    if (sel < 65) return pctd_pkg::ValueWidth'($urandom_range(0, 65535));
    if (sel < 80) return {1'b1, r[pctd_pkg::ValueWidth-2:0]};
    if (sel < 90) return {1'b0, r[pctd_pkg::ValueWidth-2:1], 1'b0};
    if (sel < 95) return pctd_pkg::ValueWidth'(3 * $urandom_range(1, 715827882));
    return pctd_pkg::ValueWidth'(5 * $urandom_range(1, 429496729));
  endfunction

  // Output side: random stall bursts, or one long hold-off when requested.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (LongHold - 1) @(negedge clk);
        hold_request = 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 16) - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Compare every accepted output beat with the oldest prediction.
  always @(posedge clk) begin
    verdict_t v;
    if (rst_n && out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        $display("%0t ERROR unexpected result: expected none, got prime %0b count %0d last %0b",
                 $time, is_prime, prime_count, last_result);
        error_count++;
      end else begin
        v = verdict_q.pop_front();
        beats_checked++;
        if (is_prime !== v.prime) begin
          $display("%0t ERROR is_prime: expected %0b, got %0b", $time, v.prime, is_prime);
          error_count++;
        end
        if (prime_count !== v.count) begin
          $display("%0t ERROR prime_count: expected %0d, got %0d",
                   $time, v.count, prime_count);
          error_count++;
        end
        if (last_result !== v.last) begin
          $display("%0t ERROR last_result: expected %0b, got %0b",
                   $time, v.last, last_result);
          error_count++;
        end
      end
    end
  end

  // Guard against a hang.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("%0t timeout with %0d results outstanding", $time, verdict_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Zero, one, negatives, the smallest primes and prime squares.
  task automatic test_small_and_negative();
    send_value(32'h8000_0000, 1'b0);
    send_value(32'hFFFF_FFFF, 1'b0);
    send_value(32'd0, 1'b0);
    send_value(32'd1, 1'b0);
    send_value(32'd2, 1'b0);
    send_value(32'd3, 1'b0);
    send_value(32'd4, 1'b0);
    send_value(32'd5, 1'b0);
    send_value(32'd9, 1'b0);
    send_value(32'd25, 1'b0);
    send_value(32'd49, 1'b1);
  endtask

  // Top of the range: the largest value is itself prime and takes the
  // full divisor sweep.
  task automatic test_range_extremes();
    send_value(32'h7FFF_FFFE, 1'b0);
    send_value(32'h7FFF_FFFF, 1'b0);
    send_value(32'h5555_5555, 1'b0);
    send_value(32'hAAAA_AAAA, 1'b1);
  endtask

  // Single-beat lists and back-to-back list ends clear the count.
  task automatic test_list_boundaries();
    send_value(32'd7, 1'b1);
    send_value(32'd11, 1'b1);
    send_value(32'd8, 1'b1);
    send_value(32'd13, 1'b0);
    send_value(32'd17, 1'b1);
  endtask

  // Hold the output off while beats keep coming, then drain completely.
  task automatic test_output_backpressure();
    int unsigned i;
    hold_request = 1'b1;
    for (i = 0; i < 6; i++) begin
      send_value(pctd_pkg::ValueWidth'($urandom_range(2, 200)), i == 5);
    end
    pause_until_drained();
  endtask

  // Random lists of random length; the tail runs without any idling.
  task automatic test_random_lists();
    int unsigned list_len;
    int unsigned pos;
    while (beats_sent < RandomBeats) begin
      list_len = $urandom_range(1, 12);
      for (pos = 0; pos < list_len; pos++) begin
        if (beats_sent >= RandomBeats - CalmBeats) idle_en = 1'b0;
        send_value(pick_value(), pos == list_len - 1);
      end
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    value        = '0;
    last_item    = 1'b0;
    prime_tally  = '0;
    idle_en      = 1'b1;
    hold_request = 1'b0;
    cycle_count  = 0;
    error_count  = 0;
    beats_sent   = 0;
    beats_checked = 0;
    primes_seen  = 0;
    lists_closed = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_small_and_negative();
    test_range_extremes();
    test_list_boundaries();
    test_output_backpressure();
    test_random_lists();

    wait (verdict_q.size() == 0);
    repeat (SettleWait) @(posedge clk);

    $display("Checked %0d of %0d values over %0d lists, %0d of them prime,",
             beats_checked, beats_sent, lists_closed, primes_seen);
    $display("with negative and top-of-range values, list ends and output stalls.");
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
